### design/bsfr_pkg.sv
package bsfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_OTHER        = 2'd0,
    KIND_SET_VALUE    = 2'd1,
    KIND_SET_ACK      = 2'd2,
    KIND_MEASURED     = 2'd3
  } frame_kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_XOR = 1'd1;

  localparam byte_t FLAG_RESET     = 8'h7E;
  localparam byte_t ESC_XOR_RESET  = 8'h20;
  localparam byte_t ESC_BYTE       = 8'h7D;
  localparam byte_t CMD_SET_POINT  = 8'h00;
  localparam byte_t CMD_MEASURED   = 8'h08;

endpackage

### design/bsfr_if.sv
interface bsfr_byte_if;
  import bsfr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_frame_if;
  import bsfr_pkg::*;

  logic        valid;
  logic        ready;
  byte_t       frame_address;
  byte_t       frame_command;
  byte_t       frame_status;
  byte_t       frame_length;
  word_t       payload_word;
  logic        check_ok;
  frame_kind_t frame_kind;

  modport source (output valid, output frame_address, output frame_command,
                  output frame_status, output frame_length, output payload_word,
                  output check_ok, output frame_kind, input ready);
  modport sink   (input valid, input frame_address, input frame_command,
                  input frame_status, input frame_length, input payload_word,
                  input check_ok, input frame_kind, output ready);
endinterface

### design/byte_stuffed_frame_receiver.sv
// Pipeline: a closing flag beat is captured in the input register; its result is then
//   captured in the result register and shown at the output.
// Throughput: one byte beat per cycle, sustained; the only stall comes from a result beat
//   that cannot leave the output register while the next closing flag waits behind it.
// Reset (rst, synchronous, active high): flag 0x7E, escape XOR 0x20, hunting for an
//   opening flag, both pipeline registers empty.
module byte_stuffed_frame_receiver (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [bsfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  bsfr_pkg::byte_t               cfg_data,
  bsfr_byte_if.sink                     rx,
  bsfr_frame_if.source                  frame
);
  import bsfr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT, PH_ADDR, PH_CMD, PH_STAT, PH_LEN, PH_DATA, PH_CHK, PH_CLOSE
  } phase_t;

  // Configuration registers
  byte_t flag_byte;
  byte_t escape_xor;

  // Input register: one raw byte beat waiting for the deframer
  logic  in_valid;
  byte_t in_byte;

  // Frame state
  phase_t phase, phase_next;
  logic   esc_pending, esc_pending_next;
  byte_t  address_hold, address_hold_next;
  byte_t  command_hold, command_hold_next;
  byte_t  status_hold, status_hold_next;
  byte_t  length_hold, length_hold_next;
  byte_t  data_remaining, data_remaining_next;
  byte_t  running_sum, running_sum_next;
  word_t  value_shift, value_shift_next;
  byte_t  checksum_hold, checksum_hold_next;

  // Result register
  logic out_valid;

  logic        is_flag;
  logic        is_result;
  logic        out_free;
  logic        advance;
  logic        take_byte;
  byte_t       data_byte;
  frame_kind_t kind;

  assign is_flag   = (in_byte == flag_byte);
  assign is_result = is_flag && (phase == PH_CLOSE);
  // The result register frees up either when it is empty or when its beat leaves now.
  assign out_free  = !out_valid || frame.ready;
  // A byte beat that closes a frame must wait for room in the result register;
  // every other beat moves on at once.
  assign advance   = in_valid && (!is_result || out_free);
  assign rx.ready  = !in_valid || advance;

  always_comb begin
    priority if (command_hold == CMD_SET_POINT) begin
      kind = (length_hold != '0) ? KIND_SET_VALUE : KIND_SET_ACK;
    end else if (command_hold == CMD_MEASURED) begin
      kind = KIND_MEASURED;
    end else begin
      kind = KIND_OTHER;
    end
  end

  // Unescape: a pending escape XORs this byte; a bare escape byte is swallowed.
  always_comb begin
    take_byte = 1'b0;
    data_byte = in_byte;
    esc_pending_next = esc_pending;
    if (esc_pending) begin
      data_byte = in_byte ^ escape_xor;
      take_byte = 1'b1;
      esc_pending_next = 1'b0;
    end else if (in_byte == ESC_BYTE) begin
      esc_pending_next = 1'b1;
    end else begin
      take_byte = 1'b1;
    end
    // Flags and ignored phases never touch the escape state through this path.
    if (is_flag || phase == PH_HUNT || phase == PH_CLOSE) begin
      take_byte = 1'b0;
      esc_pending_next = esc_pending;
    end
  end

  always_comb begin
    phase_next          = phase;
    address_hold_next   = address_hold;
    command_hold_next   = command_hold;
    status_hold_next    = status_hold;
    length_hold_next    = length_hold;
    data_remaining_next = data_remaining;
    running_sum_next    = running_sum;
    value_shift_next    = value_shift;
    checksum_hold_next  = checksum_hold;
    if (is_flag) begin
      if (phase == PH_CLOSE) begin
        // Closing flag: emit and go back to hunting.
        phase_next = PH_HUNT;
      end else begin
        // Opening flag, or an early one: restart the frame from scratch.
        phase_next          = PH_ADDR;
        address_hold_next   = '0;
        command_hold_next   = '0;
        status_hold_next    = '0;
        length_hold_next    = '0;
        data_remaining_next = '0;
        running_sum_next    = '0;
        value_shift_next    = '0;
        checksum_hold_next  = '0;
      end
    end else if (take_byte) begin
      unique case (phase)
        PH_ADDR: begin
          address_hold_next = data_byte;
          running_sum_next  = running_sum + data_byte;
          phase_next        = PH_CMD;
        end
        PH_CMD: begin
          command_hold_next = data_byte;
          running_sum_next  = running_sum + data_byte;
          phase_next        = PH_STAT;
        end
        PH_STAT: begin
          status_hold_next = data_byte;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          length_hold_next    = data_byte;
          data_remaining_next = data_byte;
          running_sum_next    = running_sum + data_byte;
          phase_next          = (data_byte == '0) ? PH_CHK : PH_DATA;
        end
        PH_DATA: begin
          running_sum_next    = running_sum + data_byte;
          value_shift_next    = {value_shift[WORD_W-BYTE_W-1:0], data_byte};
          data_remaining_next = data_remaining - 1'b1;
          if (data_remaining_next == '0) begin
            phase_next = PH_CHK;
          end
        end
        PH_CHK: begin
          checksum_hold_next = data_byte;
          phase_next         = PH_CLOSE;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // Configuration: the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte  <= FLAG_RESET;
      escape_xor <= ESC_XOR_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_FLAG_BYTE:  flag_byte  <= cfg_data;
        REG_ESCAPE_XOR: escape_xor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: load a new beat whenever it is empty or the current one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Deframer state and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      esc_pending    <= 1'b0;
      address_hold   <= '0;
      command_hold   <= '0;
      status_hold    <= '0;
      length_hold    <= '0;
      data_remaining <= '0;
      running_sum    <= '0;
      value_shift    <= '0;
      checksum_hold  <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        phase          <= phase_next;
        esc_pending    <= is_flag ? 1'b0 : esc_pending_next;
        address_hold   <= address_hold_next;
        command_hold   <= command_hold_next;
        status_hold    <= status_hold_next;
        length_hold    <= length_hold_next;
        data_remaining <= data_remaining_next;
        running_sum    <= running_sum_next;
        value_shift    <= value_shift_next;
        checksum_hold  <= checksum_hold_next;
      end
      if (advance && is_result) begin
        out_valid <= 1'b1;
      end else if (frame.ready) begin
        out_valid <= 1'b0;
      end
    end
    // Result payload: capture on the closing flag, hold while stalled.
    if (!rst && advance && is_result) begin
      frame.frame_address <= address_hold;
      frame.frame_command <= command_hold;
      frame.frame_status  <= status_hold;
      frame.frame_length  <= length_hold;
      frame.payload_word  <= value_shift;
      frame.check_ok      <= (checksum_hold == ~running_sum);
      frame.frame_kind    <= kind;
    end
  end

  assign frame.valid = out_valid;

  // Escapes never linger outside the body of a frame.
  a_hunt_no_escape: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_CLOSE) |-> !esc_pending)
    else $error("escape pending while hunting or closing");

  // A data phase always has bytes left to collect.
  a_data_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (data_remaining != '0))
    else $error("data phase with zero bytes remaining");

  // Emitting a result drops the deframer back to hunting.
  a_emit_hunts: assert property (@(posedge clk) disable iff (rst)
    (advance && is_result) |=> (phase == PH_HUNT) && out_valid)
    else $error("result emitted without returning to hunt");

  // The input register stalls only behind a closing flag whose result beat is blocked.
  a_emit_from_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> (is_result && out_valid && !frame.ready))
    else $error("input register stalled without a blocked result");

endmodule

### tb/tb_byte_stuffed_frame_receiver.sv
`timescale 1ns / 1ps

module tb_byte_stuffed_frame_receiver;
  import bsfr_pkg::*;

  // Longest stretch without any handshake or register write before we give up.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Cycles to let pass once nothing is expected: covers the two-register pipe
  // plus a byte that may still sit in the input register.
  localparam int unsigned DRAIN_CYCLES = 6;
  // Link bytes generated per flag/escape setting.
  localparam int unsigned PHASE_BYTES  = 270;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned NUM_RESETUPS = 6;

  // Where the deframer stands within a frame.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDRESS,
    ST_COMMAND,
    ST_STATUS,
    ST_LENGTH,
    ST_DATA,
    ST_CHECKSUM,
    ST_TRAILER
  } link_state_t;

  typedef struct packed {
    byte_t       address;
    byte_t       command;
    byte_t       status;
    byte_t       length;
    word_t       payload;
    logic        check_ok;
    frame_kind_t kind;
  } frame_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  byte_t                cfg_data     = '0;

  bsfr_byte_if  byte_ch ();
  bsfr_frame_if frame_ch ();

  byte_stuffed_frame_receiver DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rx           (byte_ch),
    .frame        (frame_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Raw link bytes waiting to be sent, and decoded frames waiting to come out.
  byte_t  wire_bytes[$];
  frame_t frames_due[$];

  // Current register contents, shared by the stream builder and the deframer model.
  byte_t flag_cfg = FLAG_RESET;
  byte_t xor_cfg  = ESC_XOR_RESET;

  // Deframer model state.
  link_state_t link_st   = ST_IDLE;
  bit          esc_armed = 1'b0;
  byte_t       addr_q    = '0;
  byte_t       cmd_q     = '0;
  byte_t       stat_q    = '0;
  byte_t       len_q     = '0;
  byte_t       left_q    = '0;
  byte_t       sum_q     = '0;
  word_t       tail_word = '0;
  byte_t       chk_q     = '0;

  int unsigned bytes_sent     = 0;
  int unsigned frames_checked = 0;
  int unsigned bad_sums_seen  = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned settings_run   = 1;

  int unsigned tx_gap  = 0;
  int unsigned tx_run  = 0;
  bit          tx_calm = 1'b0;
  int unsigned rx_hold = 0;
  int unsigned rx_run  = 0;
  bit          rx_calm = 1'b0;

  // Draw the wait for one beat; switch now and then into a calm stretch with no waits.
  function automatic int unsigned pick_wait(inout int unsigned run_left, inout bit calm);
    if (run_left == 0) begin
      run_left = $urandom_range(20, 80);
      calm     = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // Advance the deframer model by one raw byte; queue a frame on a closing flag.
  task automatic deframe_byte(input byte_t raw);
    byte_t  b;
    bit     take;
    frame_t f;
    b    = raw;
    take = 1'b0;
    if (raw == flag_cfg) begin
      // Flag wins over everything, a pending escape included.
      if (link_st == ST_TRAILER) begin
        f.address  = addr_q;
        f.command  = cmd_q;
        f.status   = stat_q;
        f.length   = len_q;
        f.payload  = tail_word;
        f.check_ok = (chk_q == byte_t'(~sum_q));
        if (cmd_q == CMD_SET_POINT) begin
          f.kind = (len_q != 0) ? KIND_SET_VALUE : KIND_SET_ACK;
        end else if (cmd_q == CMD_MEASURED) begin
          f.kind = KIND_MEASURED;
        end else begin
          f.kind = KIND_OTHER;
        end
        frames_due.push_back(f);
        link_st = ST_IDLE;
      end else begin
        // Opening flag, or an early flag that restarts the frame.
        link_st   = ST_ADDRESS;
        addr_q    = '0;
        cmd_q     = '0;
        stat_q    = '0;
        len_q     = '0;
        left_q    = '0;
        sum_q     = '0;
        tail_word = '0;
        chk_q     = '0;
      end
      esc_armed = 1'b0;
    end else if (link_st != ST_IDLE && link_st != ST_TRAILER) begin
      if (esc_armed) begin
        b         = raw ^ xor_cfg;
        esc_armed = 1'b0;
        take      = 1'b1;
      end else if (raw == ESC_BYTE) begin
        esc_armed = 1'b1;
      end else begin
        take = 1'b1;
      end
    end
    if (take) begin
      case (link_st)
        ST_ADDRESS: begin
          addr_q  = b;
          sum_q   = sum_q + b;
          link_st = ST_COMMAND;
        end
        ST_COMMAND: begin
          cmd_q   = b;
          sum_q   = sum_q + b;
          link_st = ST_STATUS;
        end
        ST_STATUS: begin
          stat_q  = b;
          link_st = ST_LENGTH;
        end
        ST_LENGTH: begin
          len_q   = b;
          left_q  = b;
          sum_q   = sum_q + b;
          link_st = (b == 0) ? ST_CHECKSUM : ST_DATA;
        end
        ST_DATA: begin
          sum_q     = sum_q + b;
          tail_word = {tail_word[WORD_W-BYTE_W-1:0], b};
          left_q    = left_q - 1'b1;
          if (left_q == 0) link_st = ST_CHECKSUM;
        end
        ST_CHECKSUM: begin
          chk_q   = b;
          link_st = ST_TRAILER;
        end
        default: link_st = ST_IDLE;
      endcase
    end
  endtask

  // A byte can travel escaped only if its escaped form is not taken for a flag.
  function automatic bit can_escape(byte_t b);
    return flag_cfg != ESC_BYTE && byte_t'(b ^ xor_cfg) != flag_cfg;
  endfunction

  function automatic bit sendable(byte_t b);
    return (b != flag_cfg && b != ESC_BYTE) || can_escape(b);
  endfunction

  // Random field value that the current settings can carry, biased to awkward values.
  function automatic byte_t pick_field();
    byte_t b;
    do begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 6))
          0:       b = flag_cfg;
          1:       b = ESC_BYTE;
          2:       b = flag_cfg ^ xor_cfg;
          3:       b = ESC_BYTE ^ xor_cfg;
          4:       b = 8'h00;
          5:       b = 8'hFF;
          default: b = CMD_MEASURED;
        endcase
      end else begin
        b = byte_t'($urandom_range(0, 255));
      end
    end while (!sendable(b));
    return b;
  endfunction

  // Any byte but the flag; escape bytes come up often.
  function automatic byte_t junk_byte();
    byte_t b;
    do begin
      b = ($urandom_range(0, 3) == 0) ? ESC_BYTE : byte_t'($urandom_range(0, 255));
    end while (b == flag_cfg);
    return b;
  endfunction

  // Stuff one field: escape it when it must be, and sometimes when it need not be.
  task automatic put_field(input byte_t b);
    bit must;
    must = (b == flag_cfg) || (b == ESC_BYTE);
    if (can_escape(b) && (must || $urandom_range(0, 7) == 0)) begin
      wire_bytes.push_back(ESC_BYTE);
      wire_bytes.push_back(b ^ xor_cfg);
    end else begin
      wire_bytes.push_back(b);
    end
  endtask

  // Build one frame. A broken frame stops before its checksum, at times on a
  // dangling escape, so the next opening flag restarts it.
  task automatic put_frame(input int unsigned want_len, input bit broken);
    byte_t       body[$];
    byte_t       data[$];
    byte_t       addr, cmd, stat, len_b, chk, bad, sum;
    int unsigned pick, cut;
    len_b = want_len[7:0];
    while (!sendable(len_b)) len_b = byte_t'($urandom_range(0, 8));
    pick = $urandom_range(0, 3);
    cmd  = (pick == 0) ? CMD_SET_POINT : (pick == 1) ? CMD_MEASURED : pick_field();
    if (!sendable(cmd)) cmd = pick_field();
    stat = pick_field();
    sum  = cmd + len_b;
    for (int i = 0; i < len_b; i++) begin
      data.push_back(pick_field());
      sum = sum + data[i];
    end
    // Choose the address so that the correct checksum can be sent.
    do begin
      addr = pick_field();
      chk  = ~(sum + addr);
    end while (!sendable(chk));
    if ($urandom_range(0, 7) == 0) begin
      do bad = chk ^ byte_t'($urandom_range(1, 255)); while (!sendable(bad));
      chk = bad;
    end
    body = '{addr, cmd, stat, len_b};
    foreach (data[i]) body.push_back(data[i]);
    body.push_back(chk);

    wire_bytes.push_back(flag_cfg);
    cut = broken ? $urandom_range(0, body.size() - 2) : body.size();
    foreach (body[i]) begin
      if (i < cut) put_field(body[i]);
    end
    if (broken) begin
      if (flag_cfg != ESC_BYTE && $urandom_range(0, 1) == 1) wire_bytes.push_back(ESC_BYTE);
    end else begin
      // Trailing bytes between checksum and closing flag must be ignored.
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) wire_bytes.push_back(junk_byte());
      wire_bytes.push_back(flag_cfg);
    end
  endtask

  // Mostly good frames, then broken ones, line noise without flags, and raw noise.
  task automatic fill_random(input int unsigned budget, input int unsigned long_len);
    int unsigned r, len;
    if (long_len != 0) put_frame(long_len, 1'b0);
    while (wire_bytes.size() < budget) begin
      r   = $urandom_range(0, 99);
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(7, 24);
      if (r < 72) begin
        put_frame(len, 1'b0);
      end else if (r < 84) begin
        put_frame(len, 1'b1);
      end else if (r < 94) begin
        repeat ($urandom_range(1, 4)) wire_bytes.push_back(junk_byte());
      end else begin
        repeat ($urandom_range(1, 8)) begin
          wire_bytes.push_back(($urandom_range(0, 3) == 0) ? flag_cfg
                                                           : byte_t'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t value);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= value;
    if (idx == REG_FLAG_BYTE) flag_cfg = value;
    else xor_cfg = value;
  endtask

  // Hold until every byte is sent and every frame has come out, then let the pipe drain.
  task automatic wait_idle();
    while (wire_bytes.size() != 0 || byte_ch.valid || frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic string show(frame_t f);
    return $sformatf("addr=%02h cmd=%02h stat=%02h len=%02h word=%08h ok=%0b kind=%0d",
                     f.address, f.command, f.status, f.length, f.payload, f.check_ok, f.kind);
  endfunction

  task automatic note_mismatch(input string why);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("[%0t] MISMATCH %s", $time, why);
  endtask

  // Byte driver: present one beat per queued byte, with a random gap after each,
  // and feed the model at the edge where the beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        deframe_byte(byte_ch.rx_byte);
        bytes_sent++;
      end
      // A beat not yet taken stays put; otherwise idle out the gap or advance.
      if (!(byte_ch.valid && !byte_ch.ready)) begin
        if (tx_gap > 0) begin
          tx_gap--;
          byte_ch.valid <= 1'b0;
        end else if (wire_bytes.size() != 0) begin
          byte_ch.rx_byte <= wire_bytes.pop_front();
          byte_ch.valid   <= 1'b1;
          tx_gap = pick_wait(tx_run, tx_calm);
        end else begin
          byte_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Frame monitor: check each result beat against the oldest decoded frame.
  // After each beat a wait is drawn; ready stays low while it counts down, and it counts
  // down only while the next result waits, so the stall lands on a result.
  always @(posedge clk) begin
    frame_t got, want;
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      if (frame_ch.valid && frame_ch.ready) begin
        got.address  = frame_ch.frame_address;
        got.command  = frame_ch.frame_command;
        got.status   = frame_ch.frame_status;
        got.length   = frame_ch.frame_length;
        got.payload  = frame_ch.payload_word;
        got.check_ok = frame_ch.check_ok;
        got.kind     = frame_ch.frame_kind;
        frames_checked++;
        if (!got.check_ok) bad_sums_seen++;
        if (frames_due.size() == 0) begin
          note_mismatch($sformatf("frame with none pending: %s", show(got)));
        end else begin
          want = frames_due.pop_front();
          if (got.address !== want.address || got.command !== want.command ||
              got.status !== want.status || got.length !== want.length ||
              got.payload !== want.payload || got.check_ok !== want.check_ok ||
              got.kind !== want.kind) begin
            note_mismatch($sformatf("frame %0d\n  expected %s\n  actual   %s",
                                    frames_checked, show(want), show(got)));
          end
        end
        rx_hold = pick_wait(rx_run, rx_calm);
      end else if (frame_ch.valid && rx_hold > 0) begin
        rx_hold--;
      end
      frame_ch.ready <= (rx_hold == 0);
    end
  end

  // Watchdog: count cycles in which nothing moves on either side or the register port.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
        cfg_write_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    byte_t new_flag, new_xor;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    frame_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed start under reset settings:
    //  - an escape and a stray byte while hunting are dropped
    //  - set point ack with address 0xFF and zero length, good checksum
    //  - flag right after an escape restarts the frame; escape of an escape
    //    gives data; bytes and an escape after the checksum are ignored
    //  - set point with value, bad checksum
    wire_bytes = '{ESC_BYTE, 8'h00,
                   FLAG_RESET, 8'hFF, CMD_SET_POINT, 8'h00, 8'h00, 8'h00, FLAG_RESET,
                   FLAG_RESET, 8'h01, ESC_BYTE, FLAG_RESET,
                   8'h00, CMD_MEASURED, 8'hFF, 8'h01, ESC_BYTE, ESC_BYTE, 8'h99,
                   8'h55, ESC_BYTE, FLAG_RESET,
                   FLAG_RESET, 8'h12, CMD_SET_POINT, 8'h80, 8'h01, 8'hFF, 8'h00, FLAG_RESET};
    fill_random(PHASE_BYTES, 0);

    // Walk through further settings: flag equal to the escape byte, zero flag
    // with all-ones XOR, all-ones flag with zero XOR, reset values written back,
    // then random pairs. Write only once the block has gone quiet.
    for (int p = 0; p < NUM_RESETUPS; p++) begin
      wait_idle();
      case (p)
        0:       begin new_flag = ESC_BYTE;   new_xor = ESC_XOR_RESET; end
        1:       begin new_flag = 8'h00;      new_xor = 8'hFF;         end
        2:       begin new_flag = 8'hFF;      new_xor = 8'h00;         end
        3:       begin new_flag = FLAG_RESET; new_xor = ESC_XOR_RESET; end
        default: begin
          new_flag = byte_t'($urandom_range(0, 255));
          new_xor  = byte_t'($urandom_range(0, 255));
        end
      endcase
      write_reg(REG_FLAG_BYTE, new_flag);
      write_reg(REG_ESCAPE_XOR, new_xor);
      @(posedge clk);
      cfg_write_en <= 1'b0;
      settings_run++;
      // One maximum-length frame, and one long one, among the small ones.
      fill_random(PHASE_BYTES, (p == 3) ? 255 : (p == 4) ? $urandom_range(100, 254) : 0);
    end

    wait_idle();
    $display("Sent %0d link bytes under %0d flag/escape settings;", bytes_sent, settings_run);
    $display("checked %0d frames, %0d of them flagged with a bad checksum.",
             frames_checked, bad_sums_seen);
    if (mismatch_count == 0 && frames_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
